[hdl/bpk_pkg.sv]
// Shared types and constants for the MSB-first bit packer.
`default_nettype none

package bpk_pkg;

    // Largest append count; larger counts saturate to it
    localparam int MAX_APPEND = 24;
    // Most bytes one item can emit (a flush of 25 to 31 held bits)
    localparam int MAX_BYTES  = 4;
    // Output byte queue
    localparam int QDEPTH     = 8;
    localparam int QPTR_W     = 3;
    localparam int QCNT_W     = 4;

    // Item opcodes
    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    // One output beat
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } beat_t;

    // Bytes produced by one item, beats[0] leaves first
    typedef struct packed {
        logic [2:0]                n;
        beat_t [MAX_BYTES-1:0]     beats;
    } push_t;

    // Queue status seen by the packer and the top level
    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              room;
    } qstat_t;

endpackage

`default_nettype wire

[hdl/bpk_in_if.sv]
// Input channel of the bit packer: append or flush items.
`default_nettype none

interface bpk_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [4:0]  bit_count;
    logic [23:0] bit_value;

    modport source (output valid, output opcode, output bit_count, output bit_value,
                    input ready);
    modport sink   (input valid, input opcode, input bit_count, input bit_value,
                    output ready);
endinterface

`default_nettype wire

[hdl/bpk_out_if.sv]
// Output channel of the bit packer: one byte per beat.
`default_nettype none

interface bpk_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

`default_nettype wire

[hdl/bpk_pack.sv]
// Input register, accumulator state and the single-pass packing logic.
`default_nettype none

module bpk_pack
    import bpk_pkg::*;
#(
    parameter int ACC_WIDTH = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    bpk_in_if.sink     in_ch,
    input  qstat_t     qstat,
    output push_t      push
);

    logic                 item_valid_reg;
    logic                 opcode_reg;
    logic [4:0]           count_reg;
    logic [23:0]          value_reg;
    logic [ACC_WIDTH-1:0] acc_reg;
    logic [4:0]           held_reg;

    logic                 advance;
    logic [2:0]           nb;
    logic [2:0]           rem;
    logic [4:0]           cnt_sat;
    logic [23:0]          val_m;
    logic [ACC_WIDTH-1:0] acc_sh;
    logic [ACC_WIDTH-1:0] v_top;
    logic [ACC_WIDTH-1:0] acc_next;
    logic [4:0]           held_next;

    // Advance the held item once the queue can take its bytes
    assign advance     = item_valid_reg && qstat.room;
    assign in_ch.ready = !item_valid_reg || advance;

    // Work out emitted bytes and the next accumulator
    always_comb
    begin
        rem     = held_reg[2:0];
        cnt_sat = (count_reg > 5'(MAX_APPEND)) ? 5'(MAX_APPEND) : count_reg;
        val_m   = value_reg & ((24'd1 << cnt_sat) - 24'd1);
        acc_sh  = acc_reg << {held_reg[4:3], 3'b000};
        v_top   = {val_m, {(ACC_WIDTH-24){1'b0}}} << (5'(MAX_APPEND) - cnt_sat);
        if (opcode_reg == OP_FLUSH)
        begin
            nb        = 3'((6'(held_reg) + 6'd7) >> 3);
            acc_next  = '0;
            held_next = '0;
        end
        else
        begin
            nb        = {1'b0, held_reg[4:3]};
            acc_next  = acc_sh | (v_top >> rem);
            held_next = 5'({2'b00, rem} + cnt_sat);
        end
        push.n = advance ? nb : 3'd0;
        for (int i = 0; i < MAX_BYTES; i++)
        begin
            push.beats[i].out_byte = acc_reg[ACC_WIDTH-1-8*i -: 8];
            push.beats[i].last     = (3'(i + 1) == nb);
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            acc_reg        <= '0;
            held_reg       <= '0;
        end
        else
        begin
            if (in_ch.ready)
            begin
                item_valid_reg <= in_ch.valid;
            end
            if (advance)
            begin
                acc_reg  <= acc_next;
                held_reg <= held_next;
            end
        end
    end

    // Capture the item payload
    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            opcode_reg <= in_ch.opcode;
            count_reg  <= in_ch.bit_count;
            value_reg  <= in_ch.bit_value;
        end
    end

endmodule

`default_nettype wire

[hdl/bpk_byte_queue.sv]
// Output byte queue: takes up to four beats a cycle, sends one while out_ch.ready is high.
`default_nettype none

module bpk_byte_queue
    import bpk_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  push_t      push,
    bpk_out_if.source  out_ch,
    output qstat_t     qstat
);

    beat_t             q_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              pop;

    assign pop             = out_ch.valid && out_ch.ready;
    assign out_ch.valid    = (count_reg != '0);
    assign out_ch.out_byte = q_reg[rd_ptr_reg].out_byte;
    assign out_ch.last     = q_reg[rd_ptr_reg].last;

    assign qstat.count = count_reg;
    assign qstat.room  = (count_reg <= QCNT_W'(QDEPTH - MAX_BYTES));

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= QPTR_W'(wr_ptr_reg + push.n);
            if (pop)
            begin
                rd_ptr_reg <= QPTR_W'(rd_ptr_reg + 1'b1);
            end
            count_reg <= QCNT_W'(count_reg + QCNT_W'(push.n) - QCNT_W'(pop));
        end
    end

    // Store pushed beats in order
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_BYTES; i++)
        begin
            if (3'(i) < push.n)
            begin
                q_reg[QPTR_W'(wr_ptr_reg + QPTR_W'(i))] <= push.beats[i];
            end
        end
    end

endmodule

`default_nettype wire

[hdl/msb_first_bit_packer.sv]
// MSB-first bit packer: appends bit fields and emits whole bytes.
//
// in_ch carries items: opcode append (bit_count 1..24 right-aligned bits of
// bit_value, counts above 24 saturate, value bits above the count dropped)
// or flush (emit all held bits, last byte zero-padded, then clear).
// out_ch carries one byte per beat, earliest bit in bit 7; last marks the
// final byte produced by one item. Items that emit nothing send no beat.
// An accepted item waits in the input register until the byte queue has
// room; its bytes then enter the 8-entry byte queue and leave it in order.
// One item is taken per cycle while the queue has room for four more bytes;
// output drains one byte per cycle while out_ch.ready is high, so sustained
// item rate is set by the byte queue drain when items average over 8 bits.
// A receiver stall fills the queue; in_ch.ready then drops until at least
// four entries are free again. Reset empties the queue and clears the
// accumulator and bit count.
`default_nettype none

module msb_first_bit_packer
    import bpk_pkg::*;
#(
    parameter int ACC_WIDTH = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    bpk_in_if.sink     in_ch,
    bpk_out_if.source  out_ch
);

    push_t  push;
    qstat_t qstat;

    // Pack items into bytes
    bpk_pack #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_pack (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .qstat (qstat),
        .push  (push)
    );

    // Queue bytes for the receiver
    bpk_byte_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .out_ch (out_ch),
        .qstat  (qstat)
    );

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.count <= QCNT_W'(QDEPTH))
        else $error("byte queue count above depth");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.n != 3'd0) |-> qstat.room)
        else $error("bytes pushed without queue room");

    a_push_last: assert property (@(posedge clk) disable iff (!rst_n)
        (push.n != 3'd0) |-> push.beats[push.n - 3'd1].last)
        else $error("final pushed byte lacks last");

    a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid == (qstat.count != '0))
        else $error("output valid disagrees with queue count");
`endif

endmodule

`default_nettype wire

[test/tb.sv]
// Self-checking testbench for the MSB-first bit packer.
`timescale 1ns / 100ps

module tb;
    import bpk_pkg::*;

    localparam int ACC_W      = 32;
    localparam int RAND_ITEMS = 460;
    localparam int STALL_LEN  = 80;
    localparam int WD_LIMIT   = 2000;
    localparam int DRAIN_WAIT = 20;

    typedef struct packed {
        logic        opcode;
        logic [4:0]  bit_count;
        logic [23:0] bit_value;
    } pack_req_t;

    logic clk = 1'b0;
    logic rst_n;

    bpk_in_if  in_ch();
    bpk_out_if out_ch();

    msb_first_bit_packer #(.ACC_WIDTH(ACC_W)) u_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Pending items, expected output bytes, mirror of the packer state
    pack_req_t        req_q[$];
    beat_t            byte_q[$];
    logic [ACC_W-1:0] acc_bits = '0;
    int               held_cnt = 0;

    int offered_cnt   = 0;
    int taken_cnt     = 0;
    int flush_cnt     = 0;
    int beats_checked = 0;
    int err_cnt       = 0;
    int quiet_cycles  = 0;
    int stall_left    = 0;
    bit stall_done    = 1'b0;

    // No idling on either side in this window of accepted items
    wire steady_run  = (taken_cnt >= 250) && (taken_cnt < 350);
    // Keep the sender busy while the receiver holds off
    wire sender_busy = steady_run || ((taken_cnt >= 115) && (taken_cnt < 170));

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic flag_error(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        err_cnt++;
    endtask

    task automatic queue_req(input logic op, input int cnt, input logic [23:0] val);
        pack_req_t r;
        r.opcode    = op;
        r.bit_count = 5'(cnt);
        r.bit_value = val;
        req_q.push_back(r);
    endtask

    // Advance the packer mirror by one item and queue the bytes it emits
    task automatic pack_bits(input logic op, input logic [4:0] cnt_in,
                             input logic [23:0] val);
        beat_t            beats[MAX_BYTES];
        logic [ACC_W-1:0] field;
        int               cnt;
        int               n;
        n = 0;
        if (op == OP_FLUSH)
        begin
            // drain every held bit, last byte padded with zeros
            while (held_cnt > 0 && n < MAX_BYTES)
            begin
                beats[n].out_byte = acc_bits[ACC_W-1 -: 8];
                beats[n].last     = 1'b0;
                acc_bits          = acc_bits << 8;
                held_cnt          = (held_cnt > 8) ? held_cnt - 8 : 0;
                n++;
            end
            acc_bits = '0;
            held_cnt = 0;
        end
        else
        begin
            cnt = (cnt_in > MAX_APPEND) ? MAX_APPEND : int'(cnt_in);
            // emit complete bytes before appending
            while (held_cnt >= 8)
            begin
                beats[n].out_byte = acc_bits[ACC_W-1 -: 8];
                beats[n].last     = 1'b0;
                acc_bits          = acc_bits << 8;
                held_cnt          -= 8;
                n++;
            end
            if (cnt > 0)
            begin
                field    = ACC_W'(val) & ((ACC_W'(1) << cnt) - ACC_W'(1));
                acc_bits = acc_bits | (field << (ACC_W - held_cnt - cnt));
                held_cnt += cnt;
            end
        end
        for (int i = 0; i < n; i++)
        begin
            if (i == n - 1)
                beats[i].last = 1'b1;
            byte_q.push_back(beats[i]);
        end
    endtask

    // Driver: hold the offered beat until taken, else offer the next or idle
    always @(negedge clk)
    begin
        if (!rst_n)
            in_ch.valid <= 1'b0;
        else if (in_ch.valid && taken_cnt != offered_cnt)
            in_ch.valid <= 1'b1;
        else if (req_q.size() != 0 && (sender_busy || $urandom_range(0, 99) >= 16))
        begin
            in_ch.valid     <= 1'b1;
            in_ch.opcode    <= req_q[0].opcode;
            in_ch.bit_count <= req_q[0].bit_count;
            in_ch.bit_value <= req_q[0].bit_value;
            void'(req_q.pop_front());
            offered_cnt++;
        end
        else
            in_ch.valid <= 1'b0;
    end

    // Receiver: random stalls, plus one long hold-off to fill the byte queue
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end
        else if (!stall_done && taken_cnt >= 120)
        begin
            stall_done = 1'b1;
            stall_left = STALL_LEN - 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= steady_run || ($urandom_range(0, 99) >= 16);
    end

    // Monitor: check output beats, predict accepted items, watch for hangs
    always @(posedge clk)
    begin
        beat_t want;
        bit    moved;
        moved = 1'b0;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            moved = 1'b1;
            beats_checked++;
            if (byte_q.size() == 0)
                flag_error($sformatf("unexpected byte 0x%02h last=%0b",
                                     out_ch.out_byte, out_ch.last));
            else
            begin
                want = byte_q.pop_front();
                if (out_ch.out_byte !== want.out_byte)
                    flag_error($sformatf("out_byte 0x%02h, expected 0x%02h",
                                         out_ch.out_byte, want.out_byte));
                if (out_ch.last !== want.last)
                    flag_error($sformatf("last %0b, expected %0b on byte 0x%02h",
                                         out_ch.last, want.last, want.out_byte));
            end
        end
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            moved = 1'b1;
            if (in_ch.opcode == OP_FLUSH)
                flush_cnt++;
            pack_bits(in_ch.opcode, in_ch.bit_count, in_ch.bit_value);
            taken_cnt++;
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT)
        begin
            $display("Watchdog: no beat moved for %0d cycles", WD_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        int          r;
        int          cnt;
        logic [23:0] val;

        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.opcode     = OP_APPEND;
        in_ch.bit_count  = '0;
        in_ch.bit_value  = '0;
        out_ch.ready     = 1'b0;

        // Directed: empty flush, zero count, masking, saturation, fullest flush
        queue_req(OP_FLUSH,  0,  24'h000000);
        queue_req(OP_APPEND, 1,  24'h000001);
        queue_req(OP_APPEND, 0,  24'hFFFFFF);
        queue_req(OP_FLUSH,  0,  24'h000000);
        queue_req(OP_APPEND, 24, 24'hFFFFFF);
        queue_req(OP_APPEND, 7,  24'h00007F);
        queue_req(OP_APPEND, 24, 24'hA5A5A5);
        queue_req(OP_FLUSH,  31, 24'hFFFFFF);
        queue_req(OP_APPEND, 4,  24'hFFFFF5);
        queue_req(OP_APPEND, 31, 24'hFFFFFF);
        queue_req(OP_APPEND, 25, 24'h000000);
        queue_req(OP_APPEND, 8,  24'h123456);
        queue_req(OP_APPEND, 16, 24'hAAAAAA);
        queue_req(OP_APPEND, 3,  24'h000005);
        queue_req(OP_APPEND, 0,  24'h000000);
        queue_req(OP_FLUSH,  0,  24'h000000);
        queue_req(OP_APPEND, 24, 24'h800001);
        queue_req(OP_APPEND, 24, 24'h7FFFFE);
        queue_req(OP_APPEND, 9,  24'h0001FF);
        queue_req(OP_FLUSH,  0,  24'h000000);
        queue_req(OP_FLUSH,  0,  24'h000000);
        queue_req(OP_APPEND, 7,  24'h000055);
        queue_req(OP_FLUSH,  0,  24'h000000);

        // Random: mostly legal appends, some flushes and out-of-range counts
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            r = $urandom_range(0, 9);
            val = (r == 0) ? 24'h000000 : (r == 1) ? 24'hFFFFFF : 24'($urandom);
            r = $urandom_range(0, 99);
            if (r < 8)
                queue_req(OP_FLUSH, $urandom_range(0, 31), val);
            else
            begin
                if (r < 13)
                begin
                    cnt = $urandom_range(0, 7);
                    cnt = (cnt == 0) ? 0 : 24 + cnt;
                end
                else
                    cnt = $urandom_range(1, 24);
                queue_req(OP_APPEND, cnt, val);
            end
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for all items to be taken and all bytes to arrive
        while (req_q.size() != 0 || taken_cnt != offered_cnt)
            @(negedge clk);
        while (byte_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
        if (byte_q.size() != 0)
            flag_error($sformatf("%0d expected bytes never arrived", byte_q.size()));

        $display("Packed %0d items (%0d flushes) into %0d checked bytes, %0d errors",
                 taken_cnt, flush_cnt, beats_checked, err_cnt);
        $display("Covered saturated and zero counts, masking, full flushes, long stall");
        if (err_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
